>>> hw/rtl/ihc_pkg.sv
// shared types, constants and codes of the inner hair cell transmitter block
`timescale 1ns / 1ps

package ihc_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int MAG_W       = SAMPLE_BITS + 1;
   localparam int DATA_W      = 32;
   localparam int CSR_INDEX_W = 8;
   localparam int PROD_W      = 64;
   localparam int TERM_W      = 34;
   localparam int SCALED_W    = 26;
   localparam int NUM_W       = 34;
   localparam int REM_W       = 34;
   localparam int QUO_W       = 31;
   localparam int DIV_STEPS   = QUO_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
   localparam int POOL_SUM_W  = 37;
   localparam int LEVEL_FULL_W = 39;
   localparam int FRAC_BITS   = 30;
   localparam int LEVEL_SHIFT = 6;

   // 446.68359215096 in Q16.16, rounded
   localparam logic [DATA_W-1:0] GAIN_Q16   = 32'd29273856;
   localparam logic [6:0]        LEVEL_MUL  = 7'd100;

   localparam logic [DATA_W-1:0] OFFSET_RESET    = 32'd327680;
   localparam logic [DATA_W-1:0] HALF_RESET      = 32'd19660800;
   localparam logic [DATA_W-1:0] PGAIN_RESET     = 32'd48695802;
   localparam logic [DATA_W-1:0] REPLENISH_RESET = 32'd122956;
   localparam logic [DATA_W-1:0] LOSS_RESET      = 32'd60869671;
   localparam logic [DATA_W-1:0] REUPTAKE_RESET  = 32'd160209045;
   localparam logic [DATA_W-1:0] REPROCESS_RESET = 32'd1614510;
   localparam logic [DATA_W-1:0] CAPACITY_RESET  = 32'd1073741824;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_OFFSET    = 8'd0,
      REG_HALF      = 8'd1,
      REG_PGAIN     = 8'd2,
      REG_REPLENISH = 8'd3,
      REG_LOSS      = 8'd4,
      REG_REUPTAKE  = 8'd5,
      REG_REPROCESS = 8'd6,
      REG_CAPACITY  = 8'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_SCALE,
      MUL_PERM,
      MUL_REP,
      MUL_EJECT,
      MUL_LOSS,
      MUL_REUP,
      MUL_REPR
   } mul_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCALE,
      S_NUM,
      S_DIV,
      S_PERM,
      S_KCAP,
      S_REP,
      S_EJECT,
      S_LOSS,
      S_REUP,
      S_REPR,
      S_RCAP,
      S_UPD,
      S_OUT
   } state_type;

   typedef struct packed {
      logic       in_ready;
      mul_op_type mul_op;
      mul_op_type cap_op;
      logic       num_load;
      logic       div_step;
      logic       pool_update;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic pos;
      logic out_free;
   } status_type;

endpackage

>>> hw/rtl/ihc_if.sv
// valid/ready channel interfaces for sample, result and register write transfers
`timescale 1ns / 1ps

interface ihc_req_if;
   import ihc_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          last_in_block;
   modport source (output valid, output sample, output last_in_block, input ready);
   modport sink (input valid, input sample, input last_in_block, output ready);
endinterface

interface ihc_rsp_if;
   import ihc_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] cleft_level;
   logic              last_out;
   modport source (output valid, output cleft_level, output last_out, input ready);
   modport sink (input valid, input cleft_level, input last_out, output ready);
endinterface

interface ihc_csr_if;
   import ihc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [DATA_W-1:0]      data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/inner_hair_cell_transmitter_model.sv
// top level of the three-pool inner hair cell transmitter block
`timescale 1ns / 1ps

// Takes one signed audio sample per transfer on req_chan and returns one cleft level
// (100 times the cleft content, Q8.24, saturating) on rsp_chan, with last_out copied
// from last_in_block. Samples are handled one at a time: each steps through the 31-step
// restoring divider for the permeability ratio, which is skipped, leaving the permeability
// zero, when the drive is not positive, and through the one shared 32x32 multiplier, used
// seven times in turn (six when the divider is skipped). The next sample is taken in the
// cycle after the result is loaded into the output register, so a slow sink stalls the
// block only while a finished result still waits. Registers on csr_chan are always ready
// and should be written only while idle; a written capacity reaches free_store only
// through the refill term, and reset loads free_store with CAPACITY_RESET.
module inner_hair_cell_transmitter_model (
   input  logic      clock,
   input  logic      reset,
   ihc_req_if.sink   req_chan,
   ihc_rsp_if.source rsp_chan,
   ihc_csr_if.sink   csr_chan
);
   import ihc_pkg::*;

   cmd_type    cmd;
   status_type status;

   ihc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   ihc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

endmodule

>>> hw/rtl/ihc_ctrl.sv
// sequencer that steps one sample through scale, divide, multiply and update
`timescale 1ns / 1ps

module ihc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  ihc_pkg::status_type status,
   output ihc_pkg::cmd_type    cmd
);
   import ihc_pkg::*;

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (status.req_valid) state_in = S_SCALE;
         S_SCALE: state_in = S_NUM;
         S_NUM:   state_in = status.pos ? S_DIV : S_REP;
         S_DIV:   if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) state_in = S_PERM;
         S_PERM:  state_in = S_KCAP;
         S_KCAP:  state_in = S_REP;
         S_REP:   state_in = S_EJECT;
         S_EJECT: state_in = S_LOSS;
         S_LOSS:  state_in = S_REUP;
         S_REUP:  state_in = S_REPR;
         S_REPR:  state_in = S_RCAP;
         S_RCAP:  state_in = S_UPD;
         S_UPD:   state_in = S_OUT;
         S_OUT:   if (status.out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      div_cnt_in = div_cnt_ff;
      if (state_ff == S_NUM) begin
         div_cnt_in = '0;
      end else if (state_ff == S_DIV) begin
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   always_comb begin
      cmd = '{in_ready: 1'b0, mul_op: MUL_NONE, cap_op: MUL_NONE, num_load: 1'b0,
              div_step: 1'b0, pool_update: 1'b0, out_load: 1'b0};
      unique case (state_ff)
         S_IDLE:  cmd.in_ready = 1'b1;
         S_SCALE: cmd.mul_op = MUL_SCALE;
         S_NUM:   cmd.num_load = 1'b1;
         S_DIV:   cmd.div_step = 1'b1;
         S_PERM:  cmd.mul_op = MUL_PERM;
         S_KCAP:  cmd.cap_op = MUL_PERM;
         S_REP:   cmd.mul_op = MUL_REP;
         S_EJECT: begin
            cmd.mul_op = MUL_EJECT;
            cmd.cap_op = MUL_REP;
         end
         S_LOSS: begin
            cmd.mul_op = MUL_LOSS;
            cmd.cap_op = MUL_EJECT;
         end
         S_REUP: begin
            cmd.mul_op = MUL_REUP;
            cmd.cap_op = MUL_LOSS;
         end
         S_REPR: begin
            cmd.mul_op = MUL_REPR;
            cmd.cap_op = MUL_REUP;
         end
         S_RCAP:  cmd.cap_op = MUL_REPR;
         S_UPD:   cmd.pool_update = 1'b1;
         S_OUT:   cmd.out_load = status.out_free;
         default: cmd.in_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

endmodule

>>> hw/rtl/ihc_datapath.sv
// registers, shared multiplier, restoring divider and pool update of the block
`timescale 1ns / 1ps

module ihc_datapath (
   input  logic                clock,
   input  logic                reset,
   input  ihc_pkg::cmd_type    cmd,
   output ihc_pkg::status_type status,
   ihc_req_if.sink             req_chan,
   ihc_rsp_if.source           rsp_chan,
   ihc_csr_if.sink             csr_chan
);
   import ihc_pkg::*;

   // configuration
   logic [DATA_W-1:0] offset_ff, offset_in;
   logic [DATA_W-1:0] half_ff, half_in;
   logic [DATA_W-1:0] pgain_ff, pgain_in;
   logic [DATA_W-1:0] replenish_ff, replenish_in;
   logic [DATA_W-1:0] loss_ff, loss_in;
   logic [DATA_W-1:0] reuptake_ff, reuptake_in;
   logic [DATA_W-1:0] reprocess_ff, reprocess_in;
   logic [DATA_W-1:0] capacity_ff, capacity_in;

   // pools and permeability
   logic [DATA_W-1:0] free_ff, free_in;
   logic [DATA_W-1:0] cleft_ff, cleft_in;
   logic [DATA_W-1:0] wstore_ff, wstore_in;
   logic [DATA_W-1:0] perm_ff, perm_in;

   // per-sample working registers
   logic [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic                   last_ff, last_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [NUM_W-1:0]       den_ff, den_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic                   nbit_ff, nbit_in;
   logic [QUO_W-1:0]       quo_ff, quo_in;
   logic [TERM_W-1:0]      rep_ff, rep_in;
   logic [TERM_W-1:0]      eject_ff, eject_in;
   logic [TERM_W-1:0]      lossv_ff, lossv_in;
   logic [TERM_W-1:0]      reup_ff, reup_in;
   logic [TERM_W-1:0]      repr_ff, repr_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] level_ff, level_in;
   logic              last_out_ff, last_out_in;

   logic                   in_fire;
   logic                   neg;
   logic [MAG_W-1:0]       mag;
   logic [PROD_W-1:0]      rounded;
   logic [SCALED_W-1:0]    scaled;
   logic [NUM_W-1:0]       num;
   logic                   pos;
   logic [NUM_W-1:0]       den_calc;
   logic [REM_W:0]         shifted;
   logic                   fits;
   logic [REM_W:0]         diff;
   logic [DATA_W-1:0]      mul_a, mul_b;
   logic [TERM_W-1:0]      prod_term;
   logic signed [POOL_SUM_W-1:0] free_sum, cleft_sum, wstore_sum;
   logic [LEVEL_FULL_W-1:0] level_full;
   logic [DATA_W-1:0]      level_sat;

   function automatic logic [DATA_W-1:0] sat_pool(input logic signed [POOL_SUM_W-1:0] v);
      logic [DATA_W-1:0] r;
      if (v[POOL_SUM_W-1]) begin
         r = '0;
      end else if (|v[POOL_SUM_W-2:DATA_W]) begin
         r = '1;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   assign in_fire = cmd.in_ready && req_chan.valid;

   assign req_chan.ready = cmd.in_ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.cleft_level = level_ff;
   assign rsp_chan.last_out    = last_out_ff;

   // magnitude and rounded scale of the sample
   assign neg = sample_ff[SAMPLE_BITS-1];
   assign mag = neg ? ((MAG_W'(1) << SAMPLE_BITS) - MAG_W'(sample_ff)) : MAG_W'(sample_ff);
   assign rounded = prod_ff + (PROD_W'(1) << (SAMPLE_BITS - 2));
   assign scaled  = SCALED_W'(rounded >> (SAMPLE_BITS - 1));

   assign num = neg ? (NUM_W'(offset_ff) - NUM_W'(scaled))
                    : (NUM_W'(offset_ff) + NUM_W'(scaled));
   assign pos = !num[NUM_W-1] && (num != '0);
   assign den_calc = NUM_W'(num[NUM_W-2:0]) + NUM_W'(half_ff);

   // one quotient bit per step
   assign shifted = {rem_ff, nbit_ff};
   assign fits    = shifted >= {1'b0, den_ff};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      unique case (cmd.mul_op)
         MUL_SCALE: begin
            mul_a = DATA_W'(mag);
            mul_b = GAIN_Q16;
         end
         MUL_PERM: begin
            mul_a = pgain_ff;
            mul_b = DATA_W'(quo_ff);
         end
         MUL_REP: begin
            mul_a = replenish_ff;
            mul_b = (capacity_ff >= free_ff) ? (capacity_ff - free_ff) : '0;
         end
         MUL_EJECT: begin
            mul_a = perm_ff;
            mul_b = free_ff;
         end
         MUL_LOSS: begin
            mul_a = loss_ff;
            mul_b = cleft_ff;
         end
         MUL_REUP: begin
            mul_a = reuptake_ff;
            mul_b = cleft_ff;
         end
         MUL_REPR: begin
            mul_a = reprocess_ff;
            mul_b = wstore_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_term = prod_ff[FRAC_BITS+TERM_W-1:FRAC_BITS];

   assign free_sum = $signed(POOL_SUM_W'(free_ff)) + $signed(POOL_SUM_W'(rep_ff))
                   - $signed(POOL_SUM_W'(eject_ff)) + $signed(POOL_SUM_W'(repr_ff));
   assign cleft_sum = $signed(POOL_SUM_W'(cleft_ff)) + $signed(POOL_SUM_W'(eject_ff))
                    - $signed(POOL_SUM_W'(lossv_ff)) - $signed(POOL_SUM_W'(reup_ff));
   assign wstore_sum = $signed(POOL_SUM_W'(wstore_ff)) + $signed(POOL_SUM_W'(reup_ff))
                     - $signed(POOL_SUM_W'(repr_ff));

   assign level_full = LEVEL_FULL_W'(cleft_ff) * LEVEL_FULL_W'(LEVEL_MUL);
   assign level_sat  = level_full[LEVEL_FULL_W-1] ? '1
                                                  : level_full[LEVEL_FULL_W-2:LEVEL_SHIFT];

   assign status.req_valid = req_chan.valid;
   assign status.pos       = pos;
   assign status.out_free  = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      offset_in    = offset_ff;
      half_in      = half_ff;
      pgain_in     = pgain_ff;
      replenish_in = replenish_ff;
      loss_in      = loss_ff;
      reuptake_in  = reuptake_ff;
      reprocess_in = reprocess_ff;
      capacity_in  = capacity_ff;
      if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.index))
            REG_OFFSET:    offset_in    = csr_chan.data;
            REG_HALF:      half_in      = csr_chan.data;
            REG_PGAIN:     pgain_in     = csr_chan.data;
            REG_REPLENISH: replenish_in = csr_chan.data;
            REG_LOSS:      loss_in      = csr_chan.data;
            REG_REUPTAKE:  reuptake_in  = csr_chan.data;
            REG_REPROCESS: reprocess_in = csr_chan.data;
            REG_CAPACITY:  capacity_in  = csr_chan.data;
            default:       offset_in    = offset_ff;
         endcase
      end
   end

   always_comb begin
      free_in   = free_ff;
      cleft_in  = cleft_ff;
      wstore_in = wstore_ff;
      perm_in   = perm_ff;
      if (cmd.num_load && !pos) begin
         perm_in = '0;
      end else if (cmd.cap_op == MUL_PERM) begin
         perm_in = prod_ff[FRAC_BITS+DATA_W-1:FRAC_BITS];
      end
      if (cmd.pool_update) begin
         free_in   = sat_pool(free_sum);
         cleft_in  = sat_pool(cleft_sum);
         wstore_in = sat_pool(wstore_sum);
      end
   end

   always_comb begin
      sample_in = sample_ff;
      last_in   = last_ff;
      prod_in   = prod_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      nbit_in   = nbit_ff;
      quo_in    = quo_ff;
      rep_in    = rep_ff;
      eject_in  = eject_ff;
      lossv_in  = lossv_ff;
      reup_in   = reup_ff;
      repr_in   = repr_ff;
      if (in_fire) begin
         sample_in = req_chan.sample;
         last_in   = req_chan.last_in_block;
      end
      if (cmd.mul_op != MUL_NONE) begin
         prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      if (cmd.num_load) begin
         // first step shifts in the low bit of the numerator
         den_in  = den_calc;
         rem_in  = REM_W'(num[NUM_W-2:1]);
         nbit_in = num[0];
         quo_in  = '0;
      end
      if (cmd.div_step) begin
         rem_in  = fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
         nbit_in = 1'b0;
         quo_in  = {quo_ff[QUO_W-2:0], fits};
      end
      unique case (cmd.cap_op)
         MUL_REP:   rep_in   = prod_term;
         MUL_EJECT: eject_in = prod_term;
         MUL_LOSS:  lossv_in = prod_term;
         MUL_REUP:  reup_in  = prod_term;
         MUL_REPR:  repr_in  = prod_term;
         default:   rep_in   = rep_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      level_in     = level_ff;
      last_out_in  = last_out_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         level_in     = level_sat;
         last_out_in  = last_ff;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= OFFSET_RESET;
         half_ff      <= HALF_RESET;
         pgain_ff     <= PGAIN_RESET;
         replenish_ff <= REPLENISH_RESET;
         loss_ff      <= LOSS_RESET;
         reuptake_ff  <= REUPTAKE_RESET;
         reprocess_ff <= REPROCESS_RESET;
         capacity_ff  <= CAPACITY_RESET;
         free_ff      <= CAPACITY_RESET;
         cleft_ff     <= '0;
         wstore_ff    <= '0;
         perm_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         offset_ff    <= offset_in;
         half_ff      <= half_in;
         pgain_ff     <= pgain_in;
         replenish_ff <= replenish_in;
         loss_ff      <= loss_in;
         reuptake_ff  <= reuptake_in;
         reprocess_ff <= reprocess_in;
         capacity_ff  <= capacity_in;
         free_ff      <= free_in;
         cleft_ff     <= cleft_in;
         wstore_ff    <= wstore_in;
         perm_ff      <= perm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      nbit_ff     <= nbit_in;
      quo_ff      <= quo_in;
      rep_ff      <= rep_in;
      eject_ff    <= eject_in;
      lossv_ff    <= lossv_in;
      reup_ff     <= reup_in;
      repr_ff     <= repr_in;
      level_ff    <= level_in;
      last_out_ff <= last_out_in;
   end

endmodule

>>> tb/sv/cleft_level_checker.sv
// checker that predicts the cleft level of every sample transfer and compares the results
`timescale 1ns / 1ps

module cleft_level_checker (
   input  logic clock,
   input  logic reset,
   ihc_req_if   req_mon,
   ihc_rsp_if   rsp_mon,
   ihc_csr_if   csr_mon,
   output int   mismatch_count,
   output int   levels_pending
);
   import ihc_pkg::*;

   localparam int NUM_REGS = int'(REG_CAPACITY) + 1;

   typedef struct packed {
      logic [DATA_W-1:0] level;
      logic              last;
   } level_expect_type;

   level_expect_type  expected_levels [$];
   level_expect_type  oldest;
   logic [DATA_W-1:0] reg_file [NUM_REGS];
   logic [DATA_W-1:0] free_store;
   logic [DATA_W-1:0] cleft_content;
   logic [DATA_W-1:0] reprocess_store;
   logic [DATA_W-1:0] permeability;
   logic [DATA_W-1:0] new_level;

   function automatic logic [63:0] mul_q30(input logic [DATA_W-1:0] rate,
                                           input logic [DATA_W-1:0] pool);
      return (64'(rate) * 64'(pool)) >> FRAC_BITS;
   endfunction

   function automatic logic [DATA_W-1:0] clamp_pool(input longint value);
      if (value < 0) return '0;
      if (value > longint'(32'hFFFF_FFFF)) return '1;
      return value[DATA_W-1:0];
   endfunction

   // advances the three pools by one sample and returns the new cleft level
   task automatic step_pools(input logic signed [SAMPLE_BITS-1:0] smp,
                             output logic [DATA_W-1:0] level);
      longint      mag;
      longint      scaled;
      longint      drive;
      logic [63:0] drive_u;
      logic [63:0] ratio;
      logic [63:0] refill;
      logic [63:0] eject;
      logic [63:0] loss;
      logic [63:0] reuptake;
      logic [63:0] recycle;
      logic [63:0] lvl;
      longint      q_next;
      longint      c_next;
      longint      w_next;
      mag = (smp < 0) ? -longint'(smp) : longint'(smp);
      // round half away from zero on the magnitude, sign restored after
      scaled = (mag * longint'(GAIN_Q16) + (longint'(1) <<< (SAMPLE_BITS - 2)))
               >>> (SAMPLE_BITS - 1);
      drive = ((smp < 0) ? -scaled : scaled) + longint'(reg_file[REG_OFFSET]);
      if (drive > 0) begin
         drive_u = 64'(drive);
         ratio = (drive_u << FRAC_BITS) / (drive_u + 64'(reg_file[REG_HALF]));
         permeability = DATA_W'((64'(reg_file[REG_PGAIN]) * ratio) >> FRAC_BITS);
      end else begin
         permeability = '0;
      end
      refill = '0;
      if (reg_file[REG_CAPACITY] >= free_store) begin
         refill = mul_q30(reg_file[REG_REPLENISH], reg_file[REG_CAPACITY] - free_store);
      end
      eject    = mul_q30(permeability, free_store);
      loss     = mul_q30(reg_file[REG_LOSS], cleft_content);
      reuptake = mul_q30(reg_file[REG_REUPTAKE], cleft_content);
      recycle  = mul_q30(reg_file[REG_REPROCESS], reprocess_store);
      q_next = longint'(free_store) + longint'(refill) - longint'(eject) + longint'(recycle);
      c_next = longint'(cleft_content) + longint'(eject) - longint'(loss)
               - longint'(reuptake);
      w_next = longint'(reprocess_store) + longint'(reuptake) - longint'(recycle);
      free_store      = clamp_pool(q_next);
      cleft_content   = clamp_pool(c_next);
      reprocess_store = clamp_pool(w_next);
      lvl = (64'(cleft_content) * 64'(LEVEL_MUL)) >> LEVEL_SHIFT;
      level = (lvl > 64'hFFFF_FFFF) ? '1 : lvl[DATA_W-1:0];
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reg_file[REG_OFFSET]    = OFFSET_RESET;
         reg_file[REG_HALF]      = HALF_RESET;
         reg_file[REG_PGAIN]     = PGAIN_RESET;
         reg_file[REG_REPLENISH] = REPLENISH_RESET;
         reg_file[REG_LOSS]      = LOSS_RESET;
         reg_file[REG_REUPTAKE]  = REUPTAKE_RESET;
         reg_file[REG_REPROCESS] = REPROCESS_RESET;
         reg_file[REG_CAPACITY]  = CAPACITY_RESET;
         free_store      = CAPACITY_RESET;
         cleft_content   = '0;
         reprocess_store = '0;
         permeability    = '0;
         mismatch_count  = 0;
         expected_levels.delete();
      end else begin
         // unknown indexes leave the registers alone
         if (csr_mon.valid && csr_mon.ready && csr_mon.index <= REG_CAPACITY) begin
            reg_file[csr_mon.index[$clog2(NUM_REGS)-1:0]] = csr_mon.data;
         end
         // results are matched before this edge's sample transfer is queued
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_levels.size() == 0) begin
               $display("%0t: cleft_level transfer with nothing expected: actual %h last %b",
                        $time, rsp_mon.cleft_level, rsp_mon.last_out);
               mismatch_count++;
            end else begin
               oldest = expected_levels.pop_front();
               if (rsp_mon.cleft_level !== oldest.level) begin
                  $display("%0t: cleft_level mismatch: expected %h actual %h",
                           $time, oldest.level, rsp_mon.cleft_level);
                  mismatch_count++;
               end
               if (rsp_mon.last_out !== oldest.last) begin
                  $display("%0t: last_out mismatch: expected %b actual %b",
                           $time, oldest.last, rsp_mon.last_out);
                  mismatch_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            step_pools(req_mon.sample, new_level);
            expected_levels.push_back('{new_level, req_mon.last_in_block});
         end
      end
      levels_pending = expected_levels.size();
   end

endmodule

>>> tb/sv/tb_top.sv
// top of the inner hair cell transmitter testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
   import ihc_pkg::*;

   localparam int CLK_HALF      = 4;
   localparam int RESET_CYCLES  = 4;
   localparam int RUN_LIMIT     = 1_000_000;
   localparam int SETTLE_CYCLES = 100;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASES        = 10;
   localparam int PHASE_ITEMS   = 110;
   localparam int NUM_REGS      = int'(REG_CAPACITY) + 1;
   localparam int SAMPLE_MAX    = 2 ** (SAMPLE_BITS - 1) - 1;
   localparam int SAMPLE_MIN    = -(2 ** (SAMPLE_BITS - 1));
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_LOW = CSR_INDEX_W'(int'(REG_CAPACITY) + 1);
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED_TOP = '1;
   localparam logic [DATA_W-1:0] NOMINAL [NUM_REGS] = '{
      OFFSET_RESET, HALF_RESET, PGAIN_RESET, REPLENISH_RESET,
      LOSS_RESET, REUPTAKE_RESET, REPROCESS_RESET, CAPACITY_RESET
   };

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   mismatch_count;
   int   levels_pending;
   bit   rsp_hold_request = 1'b0;
   bit   sender_eager = 1'b0;
   logic [DATA_W-1:0] reg_image [NUM_REGS];

   ihc_req_if req_bus ();
   ihc_rsp_if rsp_bus ();
   ihc_csr_if csr_bus ();

   inner_hair_cell_transmitter_model DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   cleft_level_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_mon        (csr_bus),
      .mismatch_count (mismatch_count),
      .levels_pending (levels_pending)
   );

   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_stall_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [DATA_W-1:0] pick_setting(input logic [DATA_W-1:0] nominal);
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return $urandom;
         4, 5, 6: return nominal;
         default: return DATA_W'((64'(nominal) * $urandom_range(1, 16)) >> 2);
      endcase
   endfunction

   // triangle tone with a little noise on top
   function automatic logic signed [SAMPLE_BITS-1:0] tone_sample(input int k, input int period,
                                                                input int amp);
      int t;
      int ramp;
      int v;
      t = ((k % period) * 65536) / period;
      ramp = (t < 32768) ? 2 * t - 32768 : 98303 - 2 * t;
      v = (ramp * amp) / 32768 + int'($urandom_range(0, 16)) - 8;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      if (v < SAMPLE_MIN) v = SAMPLE_MIN;
      return SAMPLE_BITS'(v);
   endfunction

   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic last);
      int gap;
      gap = sender_eager ? 0 : pick_stall_len();
      if (gap > 0) begin
         req_bus.valid         <= 1'b0;
         req_bus.sample        <= SAMPLE_BITS'($urandom);
         req_bus.last_in_block <= 1'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.sample        <= value;
      req_bus.last_in_block <= last;
      @(negedge clock);
      while (!req_bus.ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (levels_pending != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(negedge clock);
      while (!csr_bus.ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic load_settings(input bit poke_unused);
      csr_index_type r;
      r = r.first();
      do begin
         write_reg(r, reg_image[r]);
         r = r.next();
      end while (r != r.first());
      // a loose index decode would clobber a real register here
      if (poke_unused) begin
         write_reg(REG_UNUSED_LOW, '0);
         write_reg(REG_UNUSED_TOP, '0);
      end
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_blocks(input int item_total);
      int   sent;
      int   blk_len;
      int   kind;
      int   period;
      int   amp;
      logic signed [SAMPLE_BITS-1:0] value;
      logic last;
      sent = 0;
      while (sent < item_total) begin
         blk_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 32);
         if (blk_len > item_total - sent) blk_len = item_total - sent;
         kind    = $urandom_range(0, 9);
         period  = $urandom_range(4, 80);
         case ($urandom_range(0, 2))
            0:       amp = SAMPLE_MAX;
            1:       amp = $urandom_range(0, SAMPLE_MAX);
            default: amp = $urandom_range(0, 600);
         endcase
         for (int k = 0; k < blk_len; k++) begin
            if (kind < 7) begin
               value = tone_sample(k, period, amp);
               last  = (k == blk_len - 1);
            end else begin
               // noise with a scattered block marker
               value = SAMPLE_BITS'($urandom);
               last  = 1'($urandom);
            end
            send_sample(value, last);
         end
         sent += blk_len;
      end
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold_request = 1'b0;
         end else begin
            int stall;
            stall = pick_stall_len();
            if (stall > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   initial begin
      int probe_samples [$];
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.sample        = '0;
      req_bus.last_in_block = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = '0;
      csr_bus.data          = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset settings: extremes and the edge where the drive turns non-positive
      probe_samples = '{SAMPLE_MAX, SAMPLE_MIN, 0, 1, -1, -366, -367, -368,
                        16384, -16384, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 0, 0};
      foreach (probe_samples[i]) send_sample(SAMPLE_BITS'(probe_samples[i]), 1'(i % 3 == 2));
      wait_drained();

      // everything at full scale: pools and level saturate, then the store clamps
      foreach (reg_image[i]) reg_image[i] = '1;
      reg_image[REG_HALF]     = '0;
      reg_image[REG_LOSS]     = '0;
      reg_image[REG_REUPTAKE] = '0;
      load_settings(1'b1);
      probe_samples = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, 0, 1, SAMPLE_MAX};
      foreach (probe_samples[i]) send_sample(SAMPLE_BITS'(probe_samples[i]), 1'(i[0]));
      wait_drained();

      // zero offset and half point, capacity below the store
      foreach (reg_image[i]) reg_image[i] = '0;
      reg_image[REG_PGAIN] = '1;
      load_settings(1'b0);
      probe_samples = '{0, 1, -1, SAMPLE_MAX, SAMPLE_MIN, 0};
      foreach (probe_samples[i]) send_sample(SAMPLE_BITS'(probe_samples[i]), 1'(i == 5));
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         foreach (reg_image[i]) begin
            reg_image[i] = (phase == 0 || phase == PHASES - 1) ? NOMINAL[i]
                                                               : pick_setting(NOMINAL[i]);
         end
         load_settings(phase[0]);
         sender_eager = ($urandom_range(0, 3) == 0);
         if (phase == 3) begin
            // receiver holds off while samples keep coming back to back
            rsp_hold_request = 1'b1;
            sender_eager     = 1'b1;
            run_blocks(30);
            sender_eager     = 1'b0;
            run_blocks(PHASE_ITEMS - 30);
         end else if (phase == 6) begin
            run_blocks(PHASE_ITEMS / 2);
            wait_drained();
            run_blocks(PHASE_ITEMS / 2);
         end else begin
            run_blocks(PHASE_ITEMS);
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0 && levels_pending == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
